// File: sv/aacs_pkg.sv
`default_nettype none
package aacs_pkg;

   localparam int FRAC_W  = 8;
   localparam int POS_W   = 24;
   localparam int SIZE_W  = 22;
   localparam int EDGE_W  = POS_W + 1;
   localparam int DELTA_W = 26;

   typedef logic signed [POS_W-1:0]   pos_type;
   typedef logic        [SIZE_W-1:0]  size_type;
   typedef logic signed [EDGE_W-1:0]  edge_type;
   typedef logic signed [DELTA_W-1:0] delta_type;
   typedef logic        [DELTA_W-1:0] mag_type;

   // push applied by one corner of the own box
   typedef struct packed {
      delta_type dx;
      delta_type dy;
   } corner_term_type;

   // offsets and depths seen by one corner
   typedef struct packed {
      logic      hit;
      logic      neg_x;
      logic      neg_y;
      delta_type diff_x;
      delta_type diff_y;
      delta_type dep_x;
      delta_type dep_y;
   } corner_geom_type;

endpackage
`default_nettype wire

// File: sv/aacs_req_if.sv
`default_nettype none
interface aacs_req_if;
   logic              valid;
   logic              ready;
   aacs_pkg::pos_type  own_x;
   aacs_pkg::pos_type  own_y;
   aacs_pkg::size_type own_w;
   aacs_pkg::size_type own_h;
   aacs_pkg::pos_type  other_x;
   aacs_pkg::pos_type  other_y;
   aacs_pkg::size_type other_w;
   aacs_pkg::size_type other_h;

   modport source (
      output valid, own_x, own_y, own_w, own_h, other_x, other_y, other_w, other_h,
      input  ready
   );
   modport sink (
      input  valid, own_x, own_y, own_w, own_h, other_x, other_y, other_w, other_h,
      output ready
   );
endinterface
`default_nettype wire

// File: sv/aacs_rsp_if.sv
`default_nettype none
interface aacs_rsp_if;
   logic               valid;
   logic               ready;
   logic               collided;
   aacs_pkg::delta_type own_dx;
   aacs_pkg::delta_type own_dy;
   aacs_pkg::delta_type other_dx;
   aacs_pkg::delta_type other_dy;

   modport source (
      output valid, collided, own_dx, own_dy, other_dx, other_dy,
      input  ready
   );
   modport sink (
      input  valid, collided, own_dx, own_dy, other_dx, other_dy,
      output ready
   );
endinterface
`default_nettype wire

// File: sv/aacs_corner.sv
`default_nettype none
module aacs_corner (
   input  wire aacs_pkg::corner_geom_type geom,
   output aacs_pkg::corner_term_type      term
);

   aacs_pkg::mag_type   abs_diff_x;
   aacs_pkg::mag_type   abs_diff_y;
   aacs_pkg::mag_type   abs_dep;
   aacs_pkg::delta_type half;
   aacs_pkg::delta_type push;
   logic                pick_x;
   logic                neg;

   always_comb begin
      abs_diff_x = geom.diff_x[aacs_pkg::DELTA_W-1] ? aacs_pkg::mag_type'(-geom.diff_x)
                                                    : aacs_pkg::mag_type'(geom.diff_x);
      abs_diff_y = geom.diff_y[aacs_pkg::DELTA_W-1] ? aacs_pkg::mag_type'(-geom.diff_y)
                                                    : aacs_pkg::mag_type'(geom.diff_y);
      // ties go to the y axis
      pick_x = abs_diff_x > abs_diff_y;
      if (pick_x) begin
         abs_dep = geom.dep_x[aacs_pkg::DELTA_W-1] ? aacs_pkg::mag_type'(-geom.dep_x)
                                                   : aacs_pkg::mag_type'(geom.dep_x);
         neg     = geom.neg_x;
      end else begin
         abs_dep = geom.dep_y[aacs_pkg::DELTA_W-1] ? aacs_pkg::mag_type'(-geom.dep_y)
                                                   : aacs_pkg::mag_type'(geom.dep_y);
         neg     = geom.neg_y;
      end
      half = aacs_pkg::delta_type'({1'b0, abs_dep[aacs_pkg::DELTA_W-1:1]});
      push = neg ? -half : half;
      term.dx = (geom.hit && pick_x)  ? push : '0;
      term.dy = (geom.hit && !pick_x) ? push : '0;
   end

endmodule
`default_nettype wire

// File: sv/aabb_collide_and_separate_core.sv
// a req word accepted into stage 1 moves through stages 2 and 3 into stage 4, the output
//   register, and leaves it when rsp ready is high
// throughput: one word per cycle while rsp ready is high; the pipeline has four register
//   stages, each with its own valid bit, and a stage refills while the one after it drains
// reset (synchronous, active high) empties every stage and clears trigger_only
// trigger_only is sampled with each word as it enters the first stage
`default_nettype none
module aabb_collide_and_separate_core (
   input  wire  clock,
   input  wire  reset,
   aacs_req_if.sink   req_bus,
   aacs_rsp_if.source rsp_bus,
   input  wire  csr_we,
   input  wire  csr_wdata
);

   localparam int NUM_CORNERS = 4;
   localparam int CORNER_TL = 0;
   localparam int CORNER_TR = 1;
   localparam int CORNER_BL = 2;
   localparam int CORNER_BR = 3;

   // configuration
   logic trigger_only_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_only_ff <= 1'b0;
      end else if (csr_we) begin
         trigger_only_ff <= csr_wdata;
      end
   end

   // flow control: a stage moves when it is empty or its successor moves
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_adv, s2_adv, s3_adv, s4_adv;

   assign s4_adv        = !s4_valid_ff || rsp_bus.ready;
   assign s3_adv        = !s3_valid_ff || s4_adv;
   assign s2_adv        = !s2_valid_ff || s3_adv;
   assign s1_adv        = !s1_valid_ff || s2_adv;
   assign req_bus.ready = s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_adv) begin
            s1_valid_ff <= req_bus.valid;
         end
         if (s2_adv) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_adv) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_adv) begin
            s4_valid_ff <= s3_valid_ff;
         end
      end
   end

   // stage 1: box edges (left, bottom, right, top) widened by one bit
   aacs_pkg::edge_type s1_x_ff, s1_y_ff, s1_r_ff, s1_t_ff;
   aacs_pkg::edge_type s1_ox_ff, s1_oy_ff, s1_or_ff, s1_ot_ff;
   logic               s1_trig_ff;

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_x_ff    <= {req_bus.own_x[aacs_pkg::POS_W-1], req_bus.own_x};
         s1_y_ff    <= {req_bus.own_y[aacs_pkg::POS_W-1], req_bus.own_y};
         s1_r_ff    <= {req_bus.own_x[aacs_pkg::POS_W-1], req_bus.own_x}
                     + {3'b000, req_bus.own_w};
         s1_t_ff    <= {req_bus.own_y[aacs_pkg::POS_W-1], req_bus.own_y}
                     + {3'b000, req_bus.own_h};
         s1_ox_ff   <= {req_bus.other_x[aacs_pkg::POS_W-1], req_bus.other_x};
         s1_oy_ff   <= {req_bus.other_y[aacs_pkg::POS_W-1], req_bus.other_y};
         s1_or_ff   <= {req_bus.other_x[aacs_pkg::POS_W-1], req_bus.other_x}
                     + {3'b000, req_bus.other_w};
         s1_ot_ff   <= {req_bus.other_y[aacs_pkg::POS_W-1], req_bus.other_y}
                     + {3'b000, req_bus.other_h};
         s1_trig_ff <= trigger_only_ff;
      end
   end

   // stage 2: overlap test, corner containment, corner offsets and depths
   logic s2_hit_in;
   logic in_left_in, in_right_in, in_top_in, in_bottom_in, resp_en_in;
   aacs_pkg::corner_geom_type s2_geom_in [NUM_CORNERS];
   aacs_pkg::corner_geom_type s2_geom_ff [NUM_CORNERS];
   logic                      s2_hit_ff;
   aacs_pkg::delta_type       dxl_in, dxr_in, dyy_in, depxl_in, depxr_in, depyt_in, depyb_in;

   function automatic aacs_pkg::delta_type sub_edge(aacs_pkg::edge_type a,
                                                    aacs_pkg::edge_type b);
      return {a[aacs_pkg::EDGE_W-1], a} - {b[aacs_pkg::EDGE_W-1], b};
   endfunction

   always_comb begin
      // inclusive compares: touching boxes collide
      s2_hit_in = !(s1_t_ff < s1_oy_ff || s1_ot_ff < s1_y_ff ||
                    s1_r_ff < s1_ox_ff || s1_or_ff < s1_x_ff);
      resp_en_in   = s2_hit_in && !s1_trig_ff;
      in_left_in   = (s1_x_ff >= s1_ox_ff) && (s1_x_ff <= s1_or_ff);
      in_right_in  = (s1_r_ff >= s1_ox_ff) && (s1_r_ff <= s1_or_ff);
      in_top_in    = (s1_t_ff >= s1_oy_ff) && (s1_t_ff <= s1_ot_ff);
      in_bottom_in = (s1_y_ff >= s1_oy_ff) && (s1_y_ff <= s1_ot_ff);

      // y offset always compares bottom edges
      dxl_in   = sub_edge(s1_x_ff, s1_ox_ff);
      dxr_in   = sub_edge(s1_r_ff, s1_or_ff);
      dyy_in   = sub_edge(s1_y_ff, s1_oy_ff);
      depxl_in = sub_edge(s1_x_ff, s1_or_ff);
      depxr_in = sub_edge(s1_r_ff, s1_ox_ff);
      depyt_in = sub_edge(s1_t_ff, s1_oy_ff);
      depyb_in = sub_edge(s1_y_ff, s1_ot_ff);

      // top-left pushes right and down
      s2_geom_in[CORNER_TL] = '{hit: resp_en_in && in_left_in && in_top_in,
                                neg_x: 1'b0, neg_y: 1'b1,
                                diff_x: dxl_in, diff_y: dyy_in,
                                dep_x: depxl_in, dep_y: depyt_in};
      // top-right pushes left and down
      s2_geom_in[CORNER_TR] = '{hit: resp_en_in && in_right_in && in_top_in,
                                neg_x: 1'b1, neg_y: 1'b1,
                                diff_x: dxr_in, diff_y: dyy_in,
                                dep_x: depxr_in, dep_y: depyt_in};
      // bottom-left pushes right and up
      s2_geom_in[CORNER_BL] = '{hit: resp_en_in && in_left_in && in_bottom_in,
                                neg_x: 1'b0, neg_y: 1'b0,
                                diff_x: dxl_in, diff_y: dyy_in,
                                dep_x: depxl_in, dep_y: depyb_in};
      // bottom-right pushes left and up
      s2_geom_in[CORNER_BR] = '{hit: resp_en_in && in_right_in && in_bottom_in,
                                neg_x: 1'b1, neg_y: 1'b0,
                                diff_x: dxr_in, diff_y: dyy_in,
                                dep_x: depxr_in, dep_y: depyb_in};
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         s2_hit_ff  <= s2_hit_in;
         s2_geom_ff <= s2_geom_in;
      end
   end

   // stage 3: per corner axis choice and half depth
   aacs_pkg::corner_term_type s3_term_in [NUM_CORNERS];
   aacs_pkg::corner_term_type s3_term_ff [NUM_CORNERS];
   logic                      s3_hit_ff;

   for (genvar c = 0; c < NUM_CORNERS; c++) begin : g_corner
      aacs_corner u_corner (
         .geom (s2_geom_ff[c]),
         .term (s3_term_in[c])
      );
   end

   always_ff @(posedge clock) begin
      if (s3_adv) begin
         s3_hit_ff  <= s2_hit_ff;
         s3_term_ff <= s3_term_in;
      end
   end

   // stage 4: sum of corner pushes, and its negation for the other box, into the output register
   aacs_pkg::delta_type sum_dx_in, sum_dy_in;
   logic                s4_hit_ff;
   aacs_pkg::delta_type s4_own_dx_ff, s4_own_dy_ff, s4_other_dx_ff, s4_other_dy_ff;

   always_comb begin
      sum_dx_in = s3_term_ff[CORNER_TL].dx + s3_term_ff[CORNER_TR].dx
                + s3_term_ff[CORNER_BL].dx + s3_term_ff[CORNER_BR].dx;
      sum_dy_in = s3_term_ff[CORNER_TL].dy + s3_term_ff[CORNER_TR].dy
                + s3_term_ff[CORNER_BL].dy + s3_term_ff[CORNER_BR].dy;
   end

   always_ff @(posedge clock) begin
      if (s4_adv) begin
         s4_hit_ff      <= s3_hit_ff;
         s4_own_dx_ff   <= sum_dx_in;
         s4_own_dy_ff   <= sum_dy_in;
         s4_other_dx_ff <= -sum_dx_in;
         s4_other_dy_ff <= -sum_dy_in;
      end
   end

   assign rsp_bus.valid    = s4_valid_ff;
   assign rsp_bus.collided = s4_hit_ff;
   assign rsp_bus.own_dx   = s4_own_dx_ff;
   assign rsp_bus.own_dy   = s4_own_dy_ff;
   assign rsp_bus.other_dx = s4_other_dx_ff;
   assign rsp_bus.other_dy = s4_other_dy_ff;

endmodule
`default_nettype wire

// File: sv/aacs_checker.sv
`default_nettype none
module aacs_checker (
   input wire clock,
   input wire reset,
   input wire rsp_valid,
   input wire rsp_ready,
   input wire rsp_collided,
   input wire aacs_pkg::delta_type own_dx,
   input wire aacs_pkg::delta_type own_dy,
   input wire aacs_pkg::delta_type other_dx,
   input wire aacs_pkg::delta_type other_dy
);

   a_empty_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp word present right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(own_dx) && $stable(own_dy))
      else $error("stalled rsp word changed");

   a_no_push_when_apart: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_collided |-> own_dx == '0 && own_dy == '0)
      else $error("push reported for boxes that do not touch");

   a_equal_opposite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> aacs_pkg::delta_type'(own_dx + other_dx) == '0 &&
                    aacs_pkg::delta_type'(own_dy + other_dy) == '0)
      else $error("other box push is not the negated own push");

endmodule

bind aabb_collide_and_separate_core aacs_checker u_aacs_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_collided (rsp_bus.collided),
   .own_dx       (rsp_bus.own_dx),
   .own_dy       (rsp_bus.own_dy),
   .other_dx     (rsp_bus.other_dx),
   .other_dy     (rsp_bus.other_dy)
);
`default_nettype wire
